// File: sv/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define CCA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, reset-qualified.
`define CCA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: sv/cca_pkg.sv
// Types, sizes and codes of the contiguous cell allocator.
package cca_pkg;

  localparam int CELLS    = 1024;
  localparam int ID_W     = 16;
  localparam int IDX_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W    = $clog2(CELLS + 1);
  localparam int OWNER_W  = 16;
  localparam int SIZE_W   = 11;
  localparam int START_W  = 10;
  localparam int POL_W    = 2;

  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic MODE_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_FIT   = 2'd2
  } status_t;

  typedef struct packed {
    logic               mode;
    logic [OWNER_W-1:0] owner_id;
    logic [SIZE_W-1:0]  request_size;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [START_W-1:0] start_index;
  } res_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ZERO,
    OP_PURGE,
    OP_SCAN,
    OP_FILL
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] best_start;
  } dp_stat_t;

endpackage

// File: sv/cca_dpath.sv
// Datapath: cell memory, sweep counter, hole tracker and run writer.
module cca_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cca_pkg::cmd_t             cmd,
  input  cca_pkg::req_t             req,
  input  logic [cca_pkg::POL_W-1:0] fit_policy,
  output cca_pkg::dp_stat_t         stat
);
  import cca_pkg::*;

  logic [ID_W-1:0]  mem [CELLS];

  logic [ID_W-1:0]  owner_r;
  logic [CNT_W-1:0] size_r;
  logic [CNT_W-1:0] addr_r;
  logic             rd_vld_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic [ID_W-1:0]  rd_q_r;
  logic [CNT_W-1:0] run_r;
  logic [CNT_W-1:0] best_len_r;
  logic [IDX_W-1:0] best_start_r;
  logic             found_r;

  logic             issue;
  logic             done;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [ID_W-1:0]  wdata;
  logic             is_free;
  logic             take;

  always_comb begin
    issue = 1'b0;
    done  = 1'b0;
    we    = 1'b0;
    waddr = addr_r[IDX_W-1:0];
    wdata = '0;
    unique case (cmd.op)
      OP_ZERO: begin
        we   = 1'b1;
        done = (addr_r == CNT_W'(CELLS - 1));
      end
      OP_PURGE: begin
        issue = (addr_r < CNT_W'(CELLS));
        we    = rd_vld_r && (rd_q_r == owner_r);
        waddr = rd_idx_r[IDX_W-1:0];
        done  = rd_vld_r && (rd_idx_r == CNT_W'(CELLS - 1));
      end
      OP_SCAN: begin
        // one extra slot past the end closes the last hole
        issue = (addr_r <= CNT_W'(CELLS));
        done  = rd_vld_r && (rd_idx_r == CNT_W'(CELLS));
      end
      OP_FILL: begin
        we    = 1'b1;
        waddr = best_start_r + addr_r[IDX_W-1:0];
        wdata = owner_r;
        done  = (addr_r == size_r - CNT_W'(1));
      end
      default: ;
    endcase
  end

  assign is_free = (rd_idx_r != CNT_W'(CELLS)) && (rd_q_r == '0);

  always_comb begin
    priority if (!found_r) begin
      take = 1'b1;
    end else if (fit_policy == POL_BEST) begin
      take = (run_r <= best_len_r);
    end else if (fit_policy == POL_WORST) begin
      take = (run_r > best_len_r);
    end else begin
      take = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      rd_q_r <= mem[addr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (cmd.op == OP_NONE || done) begin
        addr_r <= '0;
      end else if (cmd.op != OP_PURGE && cmd.op != OP_SCAN || issue) begin
        addr_r <= addr_r + CNT_W'(1);
      end
      if (cmd.load) begin
        found_r <= 1'b0;
      end else if (cmd.op == OP_SCAN && rd_vld_r && !is_free
                   && run_r >= size_r && take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= addr_r;
    if (cmd.load) begin
      owner_r      <= ID_W'(req.owner_id);
      size_r       <= CNT_W'(req.request_size);
      run_r        <= '0;
      best_len_r   <= '0;
      best_start_r <= '0;
    end else if (cmd.op == OP_SCAN && rd_vld_r) begin
      if (is_free) begin
        run_r <= run_r + CNT_W'(1);
      end else begin
        if (run_r >= size_r && take) begin
          best_start_r <= IDX_W'(rd_idx_r - run_r);
          best_len_r   <= run_r;
        end
        run_r <= '0;
      end
    end
  end

  assign stat = '{done: done, found: found_r, best_start: best_start_r};

endmodule

// File: sv/cca_ctrl.sv
// Controller: sequences clearing pass, owner sweep, hole scan and run fill.
module cca_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  cca_pkg::req_t      req,
  input  cca_pkg::dp_stat_t  stat,
  output cca_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               out_valid,
  output cca_pkg::res_t      out_res
);
  import cca_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_BAD,
    S_PURGE,
    S_SCAN,
    S_PICK,
    S_FILL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  res_t   out_res_r, out_res_nxt;
  logic   accept;
  logic   size_bad;

  assign accept   = start && (state_r == S_IDLE);
  assign size_bad = (req.request_size == '0) || (32'(req.request_size) > CELLS);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '{status: ST_OK, start_index: '0};
    cmd.load      = accept;
    cmd.op        = OP_NONE;
    unique case (state_r)
      S_INIT: begin
        cmd.op = OP_ZERO;
        if (stat.done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          priority if (req.mode == MODE_CLEAR) begin
            state_nxt = S_PURGE;
          end else if (size_bad) begin
            state_nxt = S_BAD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_BAD: begin
        state_nxt          = S_IDLE;
        out_valid_nxt      = 1'b1;
        out_res_nxt.status = ST_BAD_SIZE;
      end
      S_PURGE: begin
        cmd.op = OP_PURGE;
        if (stat.done) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.done) state_nxt = S_PICK;
      end
      S_PICK: begin
        if (stat.found) begin
          state_nxt = S_FILL;
        end else begin
          state_nxt          = S_IDLE;
          out_valid_nxt      = 1'b1;
          out_res_nxt.status = ST_NO_FIT;
        end
      end
      S_FILL: begin
        cmd.op = OP_FILL;
        if (stat.done) begin
          state_nxt               = S_IDLE;
          out_valid_nxt           = 1'b1;
          out_res_nxt.start_index = START_W'(stat.best_start);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: sv/contiguous_cell_allocator_unit.sv
// Top level of the contiguous cell allocator.
//
//   channel   ports                     handshake
//   request   start, busy, in_req       transfer when start && !busy
//   result    out_valid, out_res        one-cycle strobe, always taken
//   config    cfg_we, cfg_wdata         write when cfg_we
//
// From the accepting edge to the result: a clear runs one read-compare-write
// sweep of the cell memory; an allocate runs a scan sweep, a pick and a run
// fill, and one that finds no fit ends after the scan and the pick; a bad size
// answers without a sweep. The cell memory has one read and one write port.
// After reset a clearing pass zeroes the memory; busy is high
// meanwhile, configuration writes are still taken.
// The result strobe rises as busy falls; the receiver cannot stall it.
module contiguous_cell_allocator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  cca_pkg::req_t             in_req,
  output logic                      out_valid,
  output cca_pkg::res_t             out_res,
  input  logic                      cfg_we,
  input  logic [cca_pkg::POL_W-1:0] cfg_wdata
);
  import cca_pkg::*;

  logic [POL_W-1:0] fit_policy_r;
  cmd_t             cmd;
  dp_stat_t         stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= '0;
    end else if (cfg_we) begin
      fit_policy_r <= cfg_wdata;
    end
  end

  cca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (in_req),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  cca_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .req        (in_req),
    .fit_policy (fit_policy_r),
    .stat       (stat)
  );

endmodule

// File: sv/cca_checker.sv
// Port-level checks of the allocator, bound to the top level.
`include "assert_macros.svh"

module cca_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input cca_pkg::res_t out_res
);
  import cca_pkg::*;

  // an accepted request keeps the block busy until its result
  `CCA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // the result comes as the block goes idle
  `CCA_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy)
  `CCA_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  // failed requests report no start index
  `CCA_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && out_res.status != ST_OK, out_res.start_index == '0)

endmodule

bind contiguous_cell_allocator_unit cca_checker u_cca_checker (.*);

// File: sim/cca_alloc_checker.sv
// Checker for the contiguous cell allocator: mirrors the cell row, predicts each result and compares.
`timescale 1ns / 100ps

module cca_alloc_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  cca_pkg::req_t             in_req,
  input  logic                      out_valid,
  input  cca_pkg::res_t             out_res,
  input  logic                      cfg_we,
  input  logic [cca_pkg::POL_W-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        outstanding,
  output int                        placed_cnt,
  output int                        bad_size_cnt,
  output int                        no_fit_cnt
);
  import cca_pkg::*;

  localparam int REPORT_MAX = 10;

  logic [ID_W-1:0]  cell_tag [CELLS];
  logic [POL_W-1:0] fit_mode;
  res_t             expected_res_q [$];
  int               err_cnt;
  int               n_placed;
  int               n_bad;
  int               n_nofit;

  // Apply one request to the mirrored row and return the result it must give.
  function automatic res_t place_or_clear(req_t r);
    res_t res;
    int   run;
    int   best_at;
    int   best_len;
    int   i;
    bit   found;
    bit   take;
    bit   stop;
    res.status      = ST_OK;
    res.start_index = '0;
    if (r.mode == MODE_CLEAR) begin
      for (i = 0; i < CELLS; i++)
        if (cell_tag[i] == r.owner_id[ID_W-1:0]) cell_tag[i] = '0;
      n_placed++;
      return res;
    end
    if (r.request_size == 0 || r.request_size > CELLS) begin
      res.status = ST_BAD_SIZE;
      n_bad++;
      return res;
    end
    found    = 1'b0;
    stop     = 1'b0;
    run      = 0;
    best_at  = 0;
    best_len = 0;
    // a hole closes at an occupied cell or at the end of the row
    for (i = 0; i <= CELLS && !stop; i++) begin
      if (i < CELLS && cell_tag[i] == '0) begin
        run++;
      end else begin
        if (run >= r.request_size) begin
          if (!found) take = 1'b1;
          else if (fit_mode == POL_BEST) take = (run <= best_len);
          else if (fit_mode == POL_WORST) take = (run > best_len);
          else take = 1'b0;
          if (take) begin
            found    = 1'b1;
            best_at  = i - run;
            best_len = run;
          end
          if (fit_mode != POL_BEST && fit_mode != POL_WORST) stop = 1'b1;
        end
        run = 0;
      end
    end
    if (!found) begin
      res.status = ST_NO_FIT;
      n_nofit++;
      return res;
    end
    for (i = best_at; i < best_at + r.request_size && i < CELLS; i++)
      cell_tag[i] = r.owner_id[ID_W-1:0];
    res.start_index = best_at[START_W-1:0];
    n_placed++;
    return res;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      foreach (cell_tag[i]) cell_tag[i] = '0;
      fit_mode = '0;
      expected_res_q.delete();
    end else begin
      // take the result before any new transfer on the same edge
      if (out_valid) begin
        if (expected_res_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $display("%0t: unexpected result, status %0d start %0d", $realtime,
                     out_res.status, out_res.start_index);
        end else begin
          want = expected_res_q.pop_front();
          if (out_res.status !== want.status || out_res.start_index !== want.start_index) begin
            err_cnt++;
            if (err_cnt <= REPORT_MAX)
              $display("%0t: result mismatch, status exp %0d got %0d, start exp %0d got %0d",
                       $realtime, want.status, out_res.status, want.start_index,
                       out_res.start_index);
          end
        end
      end
      if (start && !busy) expected_res_q.push_back(place_or_clear(in_req));
      if (cfg_we) fit_mode = cfg_wdata;
    end
    outstanding  <= expected_res_q.size();
    mismatches   <= err_cnt;
    placed_cnt   <= n_placed;
    bad_size_cnt <= n_bad;
    no_fit_cnt   <= n_nofit;
  end

endmodule

// File: sim/tb_contiguous_cell_allocator_unit.sv
// Testbench top for the contiguous cell allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_contiguous_cell_allocator_unit;
  import cca_pkg::*;

  localparam logic             MODE_ALLOC  = ~MODE_CLEAR;
  localparam logic [POL_W-1:0] POL_FIRST   = 2'd0;
  localparam logic [POL_W-1:0] POL_SPARE   = 2'd3;
  localparam int               PHASE_ITEMS = 45;
  localparam int               STALL_LIMIT = 25000;
  localparam int               SIZE_MAX    = (1 << SIZE_W) - 1;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  req_t             in_req;
  logic             out_valid;
  res_t             out_res;
  logic             cfg_we;
  logic [POL_W-1:0] cfg_wdata;

  int mismatches;
  int outstanding;
  int placed_cnt;
  int bad_size_cnt;
  int no_fit_cnt;
  int sent_cnt;
  int stall_cycles;
  bit no_gaps;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  contiguous_cell_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cca_alloc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req       (in_req),
    .out_valid    (out_valid),
    .out_res      (out_res),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .placed_cnt   (placed_cnt),
    .bad_size_cnt (bad_size_cnt),
    .no_fit_cnt   (no_fit_cnt)
  );

  function automatic req_t mk_req(logic mode, logic [OWNER_W-1:0] owner,
                                  logic [SIZE_W-1:0] size);
    req_t r;
    r.mode         = mode;
    r.owner_id     = owner;
    r.request_size = size;
    return r;
  endfunction

  // Mostly small runs from a small owner pool so clears hit live owners.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick   = $urandom_range(99);
    r.mode = (pick < 28) ? MODE_CLEAR : MODE_ALLOC;
    pick   = $urandom_range(99);
    if (pick < 80) r.owner_id = OWNER_W'($urandom_range(12, 1));
    else if (pick < 85) r.owner_id = '0;
    else r.owner_id = OWNER_W'($urandom());
    pick = $urandom_range(99);
    if (pick < 70) r.request_size = SIZE_W'($urandom_range(48, 1));
    else if (pick < 90) r.request_size = SIZE_W'($urandom_range(300, 49));
    else if (pick < 95) r.request_size = SIZE_W'($urandom_range(CELLS, 301));
    else if ($urandom_range(3) == 0) r.request_size = '0;
    else r.request_size = SIZE_W'($urandom_range(SIZE_MAX, CELLS + 1));
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      while ($urandom_range(99) < 14) gap++;
      // now and then let the block run dry before the next transfer
      if ($urandom_range(39) == 0) gap += $urandom_range(2200, 1);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    sent_cnt++;
  endtask

  // Hold the sender until every expected result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_fit_policy(input logic [POL_W-1:0] p);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [POL_W-1:0] p, input bit steady);
    wait_drained();
    set_fit_policy(p);
    no_gaps = steady;
    repeat (PHASE_ITEMS) send_request(random_request());
  endtask

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_req    <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    no_gaps   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    set_fit_policy(POL_FIRST);

    // size limits, full row, clears and owner zero
    send_request(mk_req(MODE_ALLOC, 16'd1, '0));
    send_request(mk_req(MODE_ALLOC, 16'd1, SIZE_W'(SIZE_MAX)));
    send_request(mk_req(MODE_ALLOC, 16'd1, SIZE_W'(CELLS + 1)));
    send_request(mk_req(MODE_ALLOC, 16'hFFFF, SIZE_W'(CELLS)));
    send_request(mk_req(MODE_ALLOC, 16'd2, 11'd1));
    send_request(mk_req(MODE_CLEAR, 16'hFFFF, '0));
    send_request(mk_req(MODE_CLEAR, 16'd0, SIZE_W'(SIZE_MAX)));
    send_request(mk_req(MODE_ALLOC, 16'd0, 11'd5));
    // two equal holes of 200 at 100 and 350, last run ends on the row end
    send_request(mk_req(MODE_ALLOC, 16'd1, 11'd100));
    send_request(mk_req(MODE_ALLOC, 16'd2, 11'd200));
    send_request(mk_req(MODE_ALLOC, 16'd3, 11'd50));
    send_request(mk_req(MODE_ALLOC, 16'd4, 11'd200));
    send_request(mk_req(MODE_ALLOC, 16'd5, 11'd474));
    send_request(mk_req(MODE_CLEAR, 16'd2, '0));
    send_request(mk_req(MODE_CLEAR, 16'd4, '0));
    // worst fit tie goes to the earlier hole
    wait_drained();
    set_fit_policy(POL_WORST);
    send_request(mk_req(MODE_ALLOC, 16'd6, 11'd10));
    send_request(mk_req(MODE_CLEAR, 16'd6, '0));
    // best fit tie goes to the later hole
    wait_drained();
    set_fit_policy(POL_BEST);
    send_request(mk_req(MODE_ALLOC, 16'd7, 11'd10));
    // unused code behaves as first fit
    wait_drained();
    set_fit_policy(POL_SPARE);
    send_request(mk_req(MODE_ALLOC, 16'd8, 11'd250));
    send_request(mk_req(MODE_ALLOC, 16'd9, 11'd20));
    send_request(mk_req(MODE_CLEAR, 16'd5, '0));

    run_phase(POL_BEST, 1'b0);
    run_phase(POL_WORST, 1'b0);
    run_phase(POL_SPARE, 1'b1);
    run_phase(POL_FIRST, 1'b0);
    run_phase(POL_WORST, 1'b0);
    run_phase(POL_BEST, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d requests under first, best, worst fit and the unused policy code.",
             sent_cnt);
    $display("Results: %0d ok, %0d bad size, %0d no fit; %0d mismatches.",
             placed_cnt, bad_size_cnt, no_fit_cnt, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
